/* rtl/dpfc_pkg.sv */
package dpfc_pkg;

  localparam int VALUE_W   = 20;
  localparam int COUNT_W   = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SV_READ,
    ST_SV_CHECK,
    ST_SV_SQUARE,
    ST_SV_MARK,
    ST_IDLE,
    ST_FETCH,
    ST_PRIME,
    ST_COMPARE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

endpackage

/* rtl/dpfc_in_if.sv */
interface dpfc_in_if import dpfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/dpfc_out_if.sv */
interface dpfc_out_if import dpfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_echo;
  logic [COUNT_W-1:0] factor_count;

  modport source (output valid, output value_echo, output factor_count, input ready);
  modport sink   (input valid, input value_echo, input factor_count, output ready);
endinterface

/* rtl/distinct_prime_factor_count_top.sv */
// After reset: a clearing pass over all SIEVE_SIZE sieve entries (1024 by default), then
// the sieve, which reads each candidate, squares each prime and marks its multiples from the square;
// no item is taken meanwhile.
// Per item: trial division by each table prime until its square exceeds the rest, dividing
// again while the prime divides; a rest still above one at the end counts as one more factor.
// One item at a time; a finished result waits in the output register while the next is taken.
module distinct_prime_factor_count_top import dpfc_pkg::*; #(
  parameter int VALUE_BITS = 20
) (
  input  logic      clk,
  input  logic      rst,
  dpfc_in_if.sink   in_ch,
  dpfc_out_if.source out_ch
);

  localparam int SB         = (VALUE_BITS + 1) / 2;
  localparam int SIEVE_SIZE = 1 << SB;
  localparam int PRIME_CAP  = SIEVE_SIZE / 2;
  localparam int TA         = SB - 1;
  localparam int SQ_W       = 2 * SB;

  state_t state, state_next;

  logic [SB-1:0]         i;
  logic [SB:0]           j;
  logic [SQ_W-1:0]       sq;
  logic [SB-1:0]         total;
  logic [SB-1:0]         k;
  logic [SB-1:0]         p;
  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] rest;
  logic [COUNT_W-1:0]    count;
  logic                  found;

  logic                  out_valid;
  logic [VALUE_W-1:0]    out_echo;
  logic [COUNT_W-1:0]    out_count;

  // sieve memory
  logic          sv_we;
  logic [SB-1:0] sv_waddr;
  logic          sv_wdata;
  logic          sv_rdata;

  // prime table
  logic          tb_we;
  logic [SB-1:0] tb_rdata;

  logic [SB-1:0] mul_a;
  logic          div_start;
  logic          div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [SB-1:0]         div_rem;

  logic          in_take;
  logic          out_load;
  logic          rest_big;
  logic [COUNT_W-1:0] count_final;

  dpfc_ram #(.WIDTH(1), .DEPTH(SIEVE_SIZE)) u_sieve (
    .clk   (clk),
    .we    (sv_we),
    .waddr (sv_waddr),
    .wdata (sv_wdata),
    .raddr (i),
    .rdata (sv_rdata)
  );

  dpfc_ram #(.WIDTH(SB), .DEPTH(PRIME_CAP)) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (total[TA-1:0]),
    .wdata (i),
    .raddr (k[TA-1:0]),
    .rdata (tb_rdata)
  );

  dpfc_div #(.DIVIDEND_W(VALUE_BITS), .DIVISOR_W(SB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (p),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ch.ready);
  assign rest_big = rest > VALUE_BITS'(1);
  assign count_final = (rest_big && count != COUNT_MAX) ? count + 1'b1 : count;
  assign mul_a    = (state == ST_PRIME) ? tb_rdata : i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    sv_we       = 1'b0;
    sv_waddr    = i;
    sv_wdata    = 1'b1;
    tb_we       = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        sv_we = 1'b1;
        if (&i) begin
          state_next = ST_SV_READ;
        end
      end
      ST_SV_READ: state_next = ST_SV_CHECK;
      ST_SV_CHECK: begin
        if (sv_rdata) begin
          tb_we      = total < SB'(PRIME_CAP);
          state_next = ST_SV_SQUARE;
        end else begin
          state_next = (&i) ? ST_IDLE : ST_SV_READ;
        end
      end
      ST_SV_SQUARE: begin
        if (sq < SQ_W'(SIEVE_SIZE)) begin
          state_next = ST_SV_MARK;
        end else begin
          state_next = (&i) ? ST_IDLE : ST_SV_READ;
        end
      end
      ST_SV_MARK: begin
        if (j[SB]) begin
          state_next = (&i) ? ST_IDLE : ST_SV_READ;
        end else begin
          sv_we    = 1'b1;
          sv_waddr = j[SB-1:0];
          sv_wdata = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH:    state_next = (k < total) ? ST_PRIME : ST_FINISH;
      ST_PRIME:    state_next = ST_COMPARE;
      ST_COMPARE:  state_next = (sq > SQ_W'(rest)) ? ST_FINISH : ST_DIV_START;
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (div_rem == '0) ? ST_DIV_START : ST_FETCH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i     <= '0;
      total <= '0;
      k     <= '0;
      count <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR:     i <= (&i) ? SB'(2) : i + 1'b1;
        ST_SV_CHECK: begin
          if (sv_rdata) begin
            if (total < SB'(PRIME_CAP)) begin
              total <= total + 1'b1;
            end
          end else if (!(&i)) begin
            i <= i + 1'b1;
          end
        end
        ST_SV_SQUARE: begin
          if (!(sq < SQ_W'(SIEVE_SIZE)) && !(&i)) begin
            i <= i + 1'b1;
          end
        end
        ST_SV_MARK: begin
          if (j[SB] && !(&i)) begin
            i <= i + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            k     <= '0;
            count <= '0;
          end
        end
        ST_COMPARE: found <= 1'b0;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (div_rem == '0) begin
              found <= 1'b1;
              if (!found && count != COUNT_MAX) begin
                count <= count + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_SV_CHECK || state == ST_PRIME) begin
      sq <= {{SB{1'b0}}, mul_a} * {{SB{1'b0}}, mul_a};
    end
    if (state == ST_SV_SQUARE) begin
      j <= (SB + 1)'(sq);
    end else if (state == ST_SV_MARK) begin
      j <= j + (SB + 1)'(i);
    end
    if (state == ST_PRIME) begin
      p <= tb_rdata;
    end
    if (in_take) begin
      n    <= VALUE_BITS'(in_ch.value);
      rest <= VALUE_BITS'(in_ch.value);
    end else if (state == ST_DIV_WAIT && div_done && div_rem == '0) begin
      rest <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_echo  <= VALUE_W'(n);
      out_count <= count_final;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.value_echo   = out_echo;
  assign out_ch.factor_count = out_count;

endmodule

/* rtl/dpfc_ram.sv */
module dpfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dpfc_div.sv */
// Restoring divider, two quotient bits per cycle.
module dpfc_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int DW    = 2 * ((DIVIDEND_W + 1) / 2);
  localparam int CYC   = DW / 2;
  localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

  logic [DW-1:0]        q;
  logic [DW-1:0]        q_next;
  logic [DIVISOR_W-1:0] r;
  logic [DIVISOR_W-1:0] r_next;
  logic [DIVISOR_W:0]   t;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;

  always_comb begin
    q_next = q;
    r_next = r;
    t      = '0;
    for (int s = 0; s < 2; s++) begin
      t      = {r_next, q_next[DW-1]};
      q_next = {q_next[DW-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t         = t - {1'b0, divisor};
        q_next[0] = 1'b1;
      end
      r_next = t[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= DW'(dividend);
      r <= '0;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign quotient  = DIVIDEND_W'(q);
  assign remainder = r;

endmodule
